[hw/rtl/stable_priority_queue_assert.svh]
// assertion macros for the stable priority queue
// expects clk_i and rst_ni in the scope where a macro is used

`ifndef STABLE_PRIORITY_QUEUE_ASSERT_SVH
`define STABLE_PRIORITY_QUEUE_ASSERT_SVH

// condition implies consequence in the same cycle
`define SPQ_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// condition implies consequence in the next cycle
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/spq_pkg.sv]
// shared types, codes and defaults of the stable priority queue
// no dependencies

package spq_pkg;

  // default number of entries
  localparam int unsigned DepthDefault = 16;

  // request codes
  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_LIST   = 2'd2
  } req_e;

  // result status codes
  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_REMOVED  = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_FULL     = 3'd3,
    ST_LISTED   = 3'd4
  } status_e;

  // control states
  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_LIST = 1'b1
  } fsm_e;

  // per-cycle operation applied to the whole row of cells
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_SHIFT  = 2'd2,
    OP_ROTATE = 2'd3
  } cell_op_e;

  typedef struct packed {
    logic signed [31:0] value;
    logic signed [15:0] prio;
  } entry_t;

  typedef struct packed {
    cell_op_e op;
    entry_t   item;
  } cmd_t;

endpackage

[hw/rtl/spq_cell.sv]
// one storage cell of the queue row: holds one entry and trades with neighbors
// depends on spq_pkg

module spq_cell #(
  parameter int unsigned DEPTH = spq_pkg::DepthDefault,
  parameter int unsigned INDEX = 0
) (
  input  logic                       clk_i,
  input  spq_pkg::cmd_t              cmd_i,
  input  logic [$clog2(DEPTH+1)-1:0] cnt_i,
  input  spq_pkg::entry_t            left_i,
  input  logic                       left_keep_i,
  input  spq_pkg::entry_t            right_i,
  input  spq_pkg::entry_t            head_i,
  output spq_pkg::entry_t            entry_o,
  output logic                       keep_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] Idx     = CW'(INDEX);
  localparam logic [CW-1:0] IdxNext = CW'(INDEX + 1);

  spq_pkg::entry_t entry_q, entry_d;
  logic            occupied;

  // an occupied entry stays in place on insert when its priority does not exceed the new one
  assign occupied = (Idx < cnt_i);
  assign keep_o   = occupied && (entry_q.prio <= cmd_i.item.prio);

  // next entry selection
  always_comb begin
    entry_d = entry_q;
    case (cmd_i.op)
      spq_pkg::OP_INSERT: begin
        if (keep_o) begin
          entry_d = entry_q;
        end else if (left_keep_i) begin
          entry_d = cmd_i.item;
        end else begin
          entry_d = left_i;
        end
      end
      spq_pkg::OP_SHIFT: begin
        entry_d = right_i;
      end
      spq_pkg::OP_ROTATE: begin
        if (IdxNext < cnt_i) begin
          entry_d = right_i;
        end else if (IdxNext == cnt_i) begin
          entry_d = head_i;
        end
      end
      default: begin
        entry_d = entry_q;
      end
    endcase
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

[hw/rtl/spq_chain.sv]
// row of queue cells, head at cell zero
// depends on spq_pkg and spq_cell

module spq_chain #(
  parameter int unsigned DEPTH = spq_pkg::DepthDefault
) (
  input  logic                       clk_i,
  input  spq_pkg::cmd_t              cmd_i,
  input  logic [$clog2(DEPTH+1)-1:0] cnt_i,
  output spq_pkg::entry_t            head_o
);

  spq_pkg::entry_t entries [DEPTH];
  logic            keeps   [DEPTH];

  // cells wired to their left and right neighbors
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spq_pkg::entry_t left, right;
    logic            left_keep;

    if (i == 0) begin : g_first
      assign left      = cmd_i.item;
      assign left_keep = 1'b1;
    end else begin : g_inner
      assign left      = entries[i-1];
      assign left_keep = keeps[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right = entries[i];
    end else begin : g_body
      assign right = entries[i+1];
    end

    spq_cell #(
      .DEPTH (DEPTH),
      .INDEX (i)
    ) u_cell (
      .clk_i       (clk_i),
      .cmd_i       (cmd_i),
      .cnt_i       (cnt_i),
      .left_i      (left),
      .left_keep_i (left_keep),
      .right_i     (right),
      .head_i      (entries[0]),
      .entry_o     (entries[i]),
      .keep_o      (keeps[i])
    );
  end

  assign head_o = entries[0];

endmodule

[hw/rtl/stable_priority_queue.sv]
// Stable priority queue of up to DEPTH entries kept sorted by ascending
// priority in a row of cells; equal priorities leave in arrival order. On
// insert and remove the whole row shifts in a single step and the result
// lands in the output register the cycle after the transfer. A list request
// first enters the list state, then rotates the row by one place each cycle
// while the output is not stalled, so that every entry passes the head cell,
// which drives the output; the row is back in order when the list ends. No
// new request is taken during a list. An insert into a full queue is dropped
// with a full status.
// depends on spq_pkg, spq_chain and stable_priority_queue_assert.svh

`include "stable_priority_queue_assert.svh"

module stable_priority_queue #(
  parameter int unsigned DEPTH = spq_pkg::DepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         req_type_i,
  input  logic signed [31:0] item_value_i,
  input  logic signed [15:0] item_priority_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] out_value_o,
  output logic signed [15:0] out_priority_o,
  output logic [2:0]         status_o,
  output logic               last_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] CntFull = CW'(DEPTH);
  localparam logic [CW-1:0] CntOne  = CW'(1);

  spq_pkg::fsm_e    state_q, state_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [CW-1:0]    idx_q, idx_d;
  spq_pkg::cmd_t    cmd;
  spq_pkg::entry_t  head;

  logic             out_valid_q;
  spq_pkg::entry_t  out_entry_q, out_entry_d;
  spq_pkg::status_e out_status_q, out_status_d;
  logic             out_last_q, out_last_d;
  logic             out_load;

  logic             load_ok;
  logic             in_fire;
  logic             is_empty;
  logic             is_full;
  logic             list_last;

  assign load_ok   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != spq_pkg::FSM_IDLE) || !load_ok;
  assign in_fire   = in_valid_i && !in_stall_o;
  assign is_empty  = (cnt_q == '0);
  assign is_full   = (cnt_q == CntFull);
  assign list_last = ((idx_q + CntOne) == cnt_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      spq_pkg::FSM_IDLE: begin
        if (in_fire && (req_type_i == spq_pkg::REQ_LIST) && !is_empty) begin
          state_d = spq_pkg::FSM_LIST;
        end
      end
      spq_pkg::FSM_LIST: begin
        if (load_ok && list_last) begin
          state_d = spq_pkg::FSM_IDLE;
        end
      end
      default: begin
        state_d = spq_pkg::FSM_IDLE;
      end
    endcase
  end

  // row command, counters and result
  always_comb begin
    cmd.op       = spq_pkg::OP_HOLD;
    cmd.item     = '{value: item_value_i, prio: item_priority_i};
    cnt_d        = cnt_q;
    idx_d        = idx_q;
    out_load     = 1'b0;
    out_entry_d  = '0;
    out_status_d = spq_pkg::ST_EMPTY;
    out_last_d   = 1'b1;
    case (state_q)
      spq_pkg::FSM_IDLE: begin
        idx_d = '0;
        if (in_fire) begin
          case (req_type_i)
            spq_pkg::REQ_INSERT: begin
              out_load = 1'b1;
              if (is_full) begin
                out_status_d = spq_pkg::ST_FULL;
              end else begin
                cmd.op       = spq_pkg::OP_INSERT;
                cnt_d        = cnt_q + CntOne;
                out_status_d = spq_pkg::ST_INSERTED;
              end
            end
            spq_pkg::REQ_REMOVE: begin
              out_load = 1'b1;
              if (!is_empty) begin
                cmd.op       = spq_pkg::OP_SHIFT;
                cnt_d        = cnt_q - CntOne;
                out_entry_d  = head;
                out_status_d = spq_pkg::ST_REMOVED;
              end
            end
            spq_pkg::REQ_LIST: begin
              out_load = is_empty;
            end
            default: begin
              out_load = 1'b0;
            end
          endcase
        end
      end
      spq_pkg::FSM_LIST: begin
        if (load_ok) begin
          cmd.op       = spq_pkg::OP_ROTATE;
          idx_d        = idx_q + CntOne;
          out_load     = 1'b1;
          out_entry_d  = head;
          out_status_d = spq_pkg::ST_LISTED;
          out_last_d   = list_last;
        end
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= spq_pkg::FSM_IDLE;
      cnt_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_entry_q  <= out_entry_d;
      out_status_q <= out_status_d;
      out_last_q   <= out_last_d;
    end
  end

  spq_chain #(
    .DEPTH (DEPTH)
  ) u_chain (
    .clk_i  (clk_i),
    .cmd_i  (cmd),
    .cnt_i  (cnt_q),
    .head_o (head)
  );

  assign out_valid_o    = out_valid_q;
  assign out_value_o    = out_entry_q.value;
  assign out_priority_o = out_entry_q.prio;
  assign status_o       = out_status_q;
  assign last_o         = out_last_q;

  // checks
  `SPQ_ASSERT_SAME(a_cnt_bound, 1'b1, cnt_q <= CntFull, "fill count above depth")
  `SPQ_ASSERT_SAME(a_list_nonempty, state_q == spq_pkg::FSM_LIST, !is_empty,
                   "list running on empty queue")
  `SPQ_ASSERT_SAME(a_list_no_transfer, state_q == spq_pkg::FSM_LIST, !in_fire,
                   "request taken during list")
  `SPQ_ASSERT_NEXT(a_insert_count,
                   in_fire && (req_type_i == spq_pkg::REQ_INSERT) && !is_full,
                   cnt_q == ($past(cnt_q) + CntOne), "insert did not grow fill count")

endmodule
